### rtl/mhfl_pkg.sv
package mhfl_pkg;

  // Offset range and name size of this build.
  localparam int unsigned OffsetBits   = 16;
  localparam int unsigned MaxNameBytes = 16;
  localparam int unsigned NameIdxBits  = $clog2(MaxNameBytes);
  localparam int unsigned NameLenBits  = 5;

  localparam int unsigned CfgDataBits  = 64;
  localparam int unsigned CfgIdxBits   = 2;

  // Result word: found, header_start, header_length, insert_offset, too_long.
  localparam int unsigned ResultBits   = 1 + OffsetBits + 2 * (OffsetBits + 1) + 1;
  localparam int unsigned ResultBytes  = (ResultBits + 7) / 8;
  localparam int unsigned TdataBits    = ResultBytes * 8;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgNameLow  = 2'd0,
    CfgNameHigh = 2'd1,
    CfgNameLen  = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic                  too_long;
    logic [OffsetBits:0]   insert_offset;
    logic [OffsetBits:0]   header_length;
    logic [OffsetBits-1:0] header_start;
    logic                  found;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

### rtl/mail_header_field_locator_top.sv
// Mail header field locator. Streams a mail message in one byte per request
// on the slave side (tlast marks the final byte) and finds the first header
// field whose name begins with the configured string, compared without
// regard to ASCII case. Offset 0 always opens a header; later headers open at
// a letter after LF, until an empty line (LF or CR LF) ends the header block.
// A header's extent includes its continuation lines (those opening with SP or
// TAB) and runs to the message end if the block never closes. Exactly one
// result request leaves the master side per message, after its last byte:
// found, header start and length (zero when not found), the insertion offset
// just past the last header, and too_long when the message ran past 2^16
// bytes (offsets then saturate). Throughput is one byte per clock: each byte
// is registered, then runs through a single pass of compare and flag update
// into the state registers; on a last byte that pass also loads the result
// register. Bytes keep flowing while a result waits on the master side; only a
// last byte waits for the result register to free up. Write the name bytes
// (index 0 and 1) and the name length (index 2) only while no message is in
// flight.
module mail_header_field_locator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [mhfl_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [mhfl_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  // Message bytes.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // message_byte
  input  logic                                s_axis_tlast,  // last_byte
  // Results.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // found, header_start[16], header_length[17], insert_offset[17], too_long, zero fill
  output logic [mhfl_pkg::TdataBits-1:0]      m_axis_tdata
);

  mhfl_pkg::item_t   in_item;
  mhfl_pkg::item_t   cur_item;
  mhfl_pkg::result_t result;
  logic              cur_valid;
  logic              out_can_load;
  logic              advance;
  logic              load;

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  // Advance the held byte unless it is a last byte and the result slot is busy.
  assign advance = cur_valid && (!cur_item.last || out_can_load);
  assign load    = advance && cur_item.last;

  mhfl_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (cur_valid),
    .item_o    (cur_item)
  );

  mhfl_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (cur_item),
    .result_o    (result)
  );

  mhfl_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .result_i   (result),
    .can_load_o (out_can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (m_axis_tdata)
  );

endmodule

### rtl/mhfl_in_stage.sv
module mhfl_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  mhfl_pkg::item_t   item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output mhfl_pkg::item_t   item_o
);

  logic            valid_q;
  logic            valid_d;
  mhfl_pkg::item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/mhfl_scan.sv
module mhfl_scan (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mhfl_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [mhfl_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  input  logic                                advance_i,
  input  mhfl_pkg::item_t                     item_i,
  output mhfl_pkg::result_t                   result_o
);

  localparam int unsigned OB = mhfl_pkg::OffsetBits;
  localparam int unsigned NB = mhfl_pkg::NameLenBits;
  localparam int unsigned IB = mhfl_pkg::NameIdxBits;

  logic [7:0]    name_q [mhfl_pkg::MaxNameBytes];
  logic [NB-1:0] name_len_q;

  logic [OB:0]   offset_q,    offset_d;
  logic          after_nl_q,  after_nl_d;
  logic          pend_cr_q,   pend_cr_d;
  logic          blk_end_q,   blk_end_d;
  logic [NB-1:0] cmp_idx_q,   cmp_idx_d;
  logic          cmp_alive_q, cmp_alive_d;
  logic          match_q,     match_d;
  logic [OB-1:0] match_start_q, match_start_d;
  logic [OB:0]   match_end_q, match_end_d;
  logic [OB-1:0] cur_start_q, cur_start_d;
  logic          ext_open_q,  ext_open_d;
  logic [OB:0]   ext_end_q,   ext_end_d;
  logic          ovf_q,       ovf_d;

  logic [7:0]    b;
  logic [7:0]    bf;
  logic          sat;
  logic [OB-1:0] o;
  logic [OB:0]   nxt;
  logic          blank;
  logic          alpha;
  logic          start;
  logic [NB-1:0] n;
  logic [OB:0]   fin;
  logic [OB:0]   me;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mhfl_pkg::MaxNameBytes; i++) begin
        name_q[i] <= '0;
      end
      name_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mhfl_pkg::CfgNameLow: begin
          for (int i = 0; i < 8; i++) begin
            name_q[i] <= cfg_wdata_i[8*i +: 8];
          end
        end
        mhfl_pkg::CfgNameHigh: begin
          for (int i = 0; i < 8; i++) begin
            name_q[8+i] <= cfg_wdata_i[8*i +: 8];
          end
        end
        mhfl_pkg::CfgNameLen: begin
          name_len_q <= cfg_wdata_i[NB-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    b     = item_i.data;
    bf    = mhfl_pkg::fold_case(b);
    sat   = offset_q[OB];
    o     = sat ? {OB{1'b1}} : offset_q[OB-1:0];
    nxt   = {1'b0, o} + {{OB{1'b0}}, 1'b1};
    blank = (b == mhfl_pkg::ChSp) || (b == mhfl_pkg::ChTab);
    alpha = (bf >= 8'h61) && (bf <= 8'h7A);
    n     = (name_len_q > NB'(mhfl_pkg::MaxNameBytes)) ? NB'(mhfl_pkg::MaxNameBytes)
                                                       : name_len_q;

    ovf_d         = ovf_q || sat;
    cmp_idx_d     = cmp_idx_q;
    cmp_alive_d   = cmp_alive_q;
    match_d       = match_q;
    match_start_d = match_start_q;
    match_end_d   = match_end_q;
    cur_start_d   = cur_start_q;
    ext_end_d     = ext_end_q;

    // A line that does not open with a blank closes the open extent.
    ext_open_d = ext_open_q && !(after_nl_q && !blank);

    start = (offset_q == '0) || (after_nl_q && alpha && !blk_end_q);

    blk_end_d = blk_end_q || ((b == mhfl_pkg::ChLf) && (pend_cr_q || after_nl_q));
    pend_cr_d = !blk_end_d && after_nl_q && (b == mhfl_pkg::ChCr);

    if (start) begin
      if (match_q && (match_end_q == '0)) begin
        match_end_d = ext_end_q;
      end
      cur_start_d = o;
      ext_open_d  = 1'b1;
      ext_end_d   = {1'b0, o};
      cmp_idx_d   = '0;
      cmp_alive_d = !match_q;
      if (!match_q && (n == '0)) begin
        match_d       = 1'b1;
        match_start_d = o;
        match_end_d   = '0;
        cmp_alive_d   = 1'b0;
      end
    end

    if (cmp_alive_d && !match_d) begin
      if ((cmp_idx_d < n) &&
          (bf == mhfl_pkg::fold_case(name_q[cmp_idx_d[IB-1:0]]))) begin
        cmp_idx_d = cmp_idx_d + NB'(1);
        if (cmp_idx_d >= n) begin
          match_d       = 1'b1;
          match_start_d = cur_start_d;
          match_end_d   = '0;
          cmp_alive_d   = 1'b0;
        end
      end else begin
        cmp_alive_d = 1'b0;
      end
    end

    if (ext_open_d && (b == mhfl_pkg::ChLf)) begin
      ext_end_d = nxt;
    end

    after_nl_d = (b == mhfl_pkg::ChLf);
    offset_d   = sat ? offset_q : offset_q + (OB+1)'(1);

    // Report on the last byte.
    fin = ext_open_d ? nxt : ext_end_d;
    me  = (match_end_d != '0) ? match_end_d : fin;
    result_o.found         = match_d;
    result_o.header_start  = match_d ? match_start_d : '0;
    result_o.header_length = (match_d && (me >= {1'b0, match_start_d}))
                             ? me - {1'b0, match_start_d} : '0;
    result_o.insert_offset = fin;
    result_o.too_long      = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q      <= '0;
      after_nl_q    <= 1'b1;
      pend_cr_q     <= 1'b0;
      blk_end_q     <= 1'b0;
      cmp_idx_q     <= '0;
      cmp_alive_q   <= 1'b0;
      match_q       <= 1'b0;
      match_start_q <= '0;
      match_end_q   <= '0;
      cur_start_q   <= '0;
      ext_open_q    <= 1'b0;
      ext_end_q     <= '0;
      ovf_q         <= 1'b0;
    end else if (advance_i) begin
      if (item_i.last) begin
        // Drop all message state for the next message.
        offset_q      <= '0;
        after_nl_q    <= 1'b1;
        pend_cr_q     <= 1'b0;
        blk_end_q     <= 1'b0;
        cmp_idx_q     <= '0;
        cmp_alive_q   <= 1'b0;
        match_q       <= 1'b0;
        match_start_q <= '0;
        match_end_q   <= '0;
        cur_start_q   <= '0;
        ext_open_q    <= 1'b0;
        ext_end_q     <= '0;
        ovf_q         <= 1'b0;
      end else begin
        offset_q      <= offset_d;
        after_nl_q    <= after_nl_d;
        pend_cr_q     <= pend_cr_d;
        blk_end_q     <= blk_end_d;
        cmp_idx_q     <= cmp_idx_d;
        cmp_alive_q   <= cmp_alive_d;
        match_q       <= match_d;
        match_start_q <= match_start_d;
        match_end_q   <= match_end_d;
        cur_start_q   <= cur_start_d;
        ext_open_q    <= ext_open_d;
        ext_end_q     <= ext_end_d;
        ovf_q         <= ovf_d;
      end
    end
  end

endmodule

### rtl/mhfl_out_stage.sv
module mhfl_out_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  mhfl_pkg::result_t                   result_i,
  output logic                                can_load_o,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [mhfl_pkg::TdataBits-1:0]      data_o
);

  logic              valid_q;
  logic              valid_d;
  mhfl_pkg::result_t result_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = {{(mhfl_pkg::TdataBits - mhfl_pkg::ResultBits){1'b0}}, result_q};

endmodule

### rtl/mhfl_checker.sv
module mhfl_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tready,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [mhfl_pkg::TdataBits-1:0]      m_axis_tdata
);

  localparam int unsigned OB = mhfl_pkg::OffsetBits;

  logic [OB-1:0] hs;
  logic [OB:0]   hl;
  logic [OB:0]   ins;
  logic [OB+1:0] match_end;

  assign hs        = m_axis_tdata[OB:1];
  assign hl        = m_axis_tdata[2*OB+1:OB+1];
  assign ins       = m_axis_tdata[3*OB+2:2*OB+2];
  assign match_end = {2'b00, hs} + {1'b0, hl};

  // A waiting result is held.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Bytes always flow while the result slot is empty.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result slot");

  // No match reports zero start and length.
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> (hs == '0) && (hl == '0))
    else $error("start or length set without a match");

  // The matched header ends at or before the insertion point.
  a_match_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> match_end <= {1'b0, ins})
    else $error("matched header extends past insertion offset");

endmodule

bind mail_header_field_locator_top mhfl_checker u_mhfl_checker (.*);

### dv/mail_header_field_locator_top_tb.sv
`timescale 1ns / 1ps

module mail_header_field_locator_top_tb;

  // Watchdog limit in cycles with neither a byte nor a result request accepted.
  // The longest correct quiet stretch is a full sender gap plus a full receiver
  // stall, the pipeline registers, a drain and three register writes.
  localparam int unsigned StallLimit = 2000;
  // Stop the random part once about this many message bytes were sent.
  localparam int unsigned RandomBytes = 1700;
  // First offset past the offset range; bytes from here on saturate.
  localparam logic [mhfl_pkg::OffsetBits:0] OffsetSpan = {1'b1, {mhfl_pkg::OffsetBits{1'b0}}};

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [mhfl_pkg::CfgIdxBits-1:0]  cfg_index_i;
  logic [mhfl_pkg::CfgDataBits-1:0] cfg_wdata_i;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata;  // message_byte
  logic                             s_axis_tlast;  // last_byte
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  // found, header_start[16], header_length[17], insert_offset[17], too_long, zero fill
  logic [mhfl_pkg::TdataBits-1:0]   m_axis_tdata;

  mail_header_field_locator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Search predictor: own copy of the name registers and the per-message state.
  // ---------------------------------------------------------------------------
  logic [63:0]                     name_lo_q;
  logic [63:0]                     name_hi_q;
  logic [4:0]                      name_len_q;

  logic [mhfl_pkg::OffsetBits:0]   msg_offset;     // offset of the next byte, saturates
  bit                              at_line_start;  // previous byte was LF
  bit                              cr_seen;        // line opened with CR, LF would end block
  bit                              block_done;     // empty line seen, no more headers
  logic [4:0]                      cmp_idx;
  bit                              cmp_live;
  bit                              hit;
  logic [mhfl_pkg::OffsetBits-1:0] hit_start;
  logic [mhfl_pkg::OffsetBits:0]   hit_end;        // zero while the hit header is current
  logic [mhfl_pkg::OffsetBits-1:0] cur_start;
  bit                              ext_open;
  logic [mhfl_pkg::OffsetBits:0]   ext_end;
  bit                              saturated;

  // Results still owed by the block, oldest first.
  mhfl_pkg::result_t expected_locations[$];
  int unsigned mismatch_count;

  // Stimulus knobs: largest idle draw per side, message under construction.
  int unsigned byte_gap_max;
  int unsigned result_stall_max;
  logic [7:0]  msg_q[$];
  int unsigned random_bytes;
  int unsigned idle_cycles;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] name_char(input logic [4:0] i);
    return (i < 5'd8) ? name_lo_q[8*i[2:0] +: 8] : name_hi_q[8*i[2:0] +: 8];
  endfunction

  function automatic logic [4:0] name_span();
    return (name_len_q > mhfl_pkg::MaxNameBytes) ? 5'(mhfl_pkg::MaxNameBytes) : name_len_q;
  endfunction

  function automatic void clear_msg_state();
    msg_offset    = '0;
    at_line_start = 1'b1;
    cr_seen       = 1'b0;
    block_done    = 1'b0;
    cmp_idx       = '0;
    cmp_live      = 1'b0;
    hit           = 1'b0;
    hit_start     = '0;
    hit_end       = '0;
    cur_start     = '0;
    ext_open      = 1'b0;
    ext_end       = '0;
    saturated     = 1'b0;
  endfunction

  // Advance the search by one byte. Returns 1 with the report on a last byte.
  function automatic bit predict_field_search(input logic [7:0] b, input bit last,
                                               output mhfl_pkg::result_t res);
    bit                            first_b, line_start, blank, alpha, opens;
    logic [4:0]                    n, idx;
    logic [mhfl_pkg::OffsetBits:0] o, nxt, fin, me;
    res        = '0;
    first_b    = (msg_offset == '0);
    line_start = at_line_start;
    blank      = (b == mhfl_pkg::ChSp) || (b == mhfl_pkg::ChTab);
    alpha      = (to_lower(b) >= "a") && (to_lower(b) <= "z");
    n          = name_span();
    o          = msg_offset;
    if (o >= OffsetSpan) begin
      o         = OffsetSpan - 1'b1;
      saturated = 1'b1;
    end
    nxt = o + 1'b1;

    // A line that opens with anything but SP or TAB closes the extent.
    if (ext_open && line_start && !blank) begin
      ext_open = 1'b0;
    end
    opens = first_b || (line_start && alpha && !block_done);
    if (!block_done && (cr_seen || line_start) && b == mhfl_pkg::ChLf) begin
      block_done = 1'b1;
    end
    cr_seen = !block_done && line_start && (b == mhfl_pkg::ChCr);

    if (opens) begin
      // Freeze the end of the hit header once the next header opens.
      if (hit && hit_end == '0) begin
        hit_end = ext_end;
      end
      cur_start = o[mhfl_pkg::OffsetBits-1:0];
      ext_open  = 1'b1;
      ext_end   = o;
      cmp_idx   = '0;
      cmp_live  = !hit;
      if (cmp_live && n == '0) begin
        hit       = 1'b1;
        hit_start = o[mhfl_pkg::OffsetBits-1:0];
        hit_end   = '0;
        cmp_live  = 1'b0;
      end
    end

    if (cmp_live && !hit) begin
      idx = cmp_idx;
      if (idx < n && to_lower(b) == to_lower(name_char(idx))) begin
        idx = idx + 1'b1;
        if (idx >= n) begin
          hit       = 1'b1;
          hit_start = cur_start;
          hit_end   = '0;
          cmp_live  = 1'b0;
        end
        cmp_idx = idx;
      end else begin
        cmp_live = 1'b0;
      end
    end

    if (ext_open && b == mhfl_pkg::ChLf) begin
      ext_end = nxt;
    end
    at_line_start = (b == mhfl_pkg::ChLf);
    msg_offset    = (msg_offset < OffsetSpan) ? msg_offset + 1'b1 : OffsetSpan;

    if (!last) begin
      return 1'b0;
    end
    fin               = ext_open ? nxt : ext_end;
    res.found         = hit;
    res.insert_offset = fin;
    res.too_long      = saturated;
    if (hit) begin
      me                = (hit_end != '0) ? hit_end : fin;
      res.header_start  = hit_start;
      res.header_length = (me >= {1'b0, hit_start}) ? me - {1'b0, hit_start} : '0;
    end
    clear_msg_state();
    return 1'b1;
  endfunction

  function automatic mhfl_pkg::result_t report(input bit found, input int unsigned start,
                                               input int unsigned len,
                                               input int unsigned ins,
                                               input bit too_long);
    mhfl_pkg::result_t r;
    r.found         = found;
    r.header_start  = start[mhfl_pkg::OffsetBits-1:0];
    r.header_length = len[mhfl_pkg::OffsetBits:0];
    r.insert_offset = ins[mhfl_pkg::OffsetBits:0];
    r.too_long      = too_long;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and quiet start values for every input.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = mhfl_pkg::CfgNameLow;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall ready for a random number of cycles per result request.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, result_stall_max);
      repeat (stall) @(negedge clk_i) m_axis_tready <= 1'b0;
      @(negedge clk_i) m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each accepted result request field by field with the oldest
  // expectation.
  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  mhfl_pkg::result_t got_res;
  mhfl_pkg::result_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = mhfl_pkg::result_t'(m_axis_tdata[mhfl_pkg::ResultBits-1:0]);
      if (expected_locations.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got_res);
        mismatch_count++;
      end else begin
        want_res = expected_locations.pop_front();
        check_field("found", want_res.found, got_res.found);
        check_field("header_start", want_res.header_start, got_res.header_start);
        check_field("header_length", want_res.header_length, got_res.header_length);
        check_field("insert_offset", want_res.insert_offset, got_res.insert_offset);
        check_field("too_long", want_res.too_long, got_res.too_long);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == StallLimit) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               expected_locations.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Message side.
  // ---------------------------------------------------------------------------

  // Drive one byte after a random gap; once accepted, advance the predictor.
  // A typed expectation, where given, replaces the predicted one.
  task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                           input mhfl_pkg::result_t want);
    int unsigned       gap;
    mhfl_pkg::result_t res;
    gap = $urandom_range(0, byte_gap_max);
    repeat (gap) @(negedge clk_i) s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_field_search(b, last, res)) begin
      expected_locations.push_back(typed ? want : res);
    end
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) begin
      send_byte(msg_q[i], i == msg_q.size() - 1, 1'b0, '0);
    end
  endtask

  // Hold the sender until every owed result has arrived, then let the
  // pipeline settle before touching the registers.
  task automatic wait_until_quiet();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (expected_locations.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input mhfl_pkg::cfg_idx_e sel, input logic [63:0] value);
    @(negedge clk_i) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= sel;
      cfg_wdata_i <= value;
    end
    @(negedge clk_i) cfg_we_i <= 1'b0;
    case (sel)
      mhfl_pkg::CfgNameLow:  name_lo_q  = value;
      mhfl_pkg::CfgNameHigh: name_hi_q  = value;
      mhfl_pkg::CfgNameLen:  name_len_q = value[4:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] name_letter();
    logic [7:0] c;
    c = "a" + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 7) == 0) begin
      c = "-";
    end else if ($urandom_range(0, 1) == 1) begin
      c = c - 8'd32;
    end
    return c;
  endfunction

  task automatic random_config();
    logic [63:0] w[2];
    logic [4:0]  len;
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(0, 7))
        0: w[k] = '0;
        1: w[k] = '1;
        2: w[k] = {$urandom, $urandom};
        default: begin
          for (int j = 0; j < 8; j++) w[k][8*j +: 8] = name_letter();
        end
      endcase
    end
    case ($urandom_range(0, 7))
      0: len = 5'd0;
      1: len = 5'd16;
      2: len = 5'd31;
      3: len = 5'($urandom_range(17, 30));
      4: len = 5'($urandom_range(9, 15));
      default: len = 5'($urandom_range(1, 8));
    endcase
    write_reg(mhfl_pkg::CfgNameLow, w[0]);
    write_reg(mhfl_pkg::CfgNameHigh, w[1]);
    write_reg(mhfl_pkg::CfgNameLen, {59'd0, len});
  endtask

  task automatic push_eol();
    if ($urandom_range(0, 1) == 1) begin
      msg_q.push_back(mhfl_pkg::ChCr);
    end
    msg_q.push_back(mhfl_pkg::ChLf);
  endtask

  task automatic push_value();
    repeat ($urandom_range(0, 6)) msg_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
  endtask

  // Append one header line, often named after the configured string with
  // random case, sometimes with only a prefix of it, plus continuation lines.
  task automatic append_header(input bit use_name);
    logic [7:0]  c;
    int unsigned cut;
    case (use_name ? $urandom_range(0, 3) : 2)
      0, 1: begin
        for (int i = 0; i < name_span(); i++) begin
          c = name_char(5'(i));
          if (to_lower(c) >= "a" && to_lower(c) <= "z" && $urandom_range(0, 1) == 1) begin
            c = c ^ 8'h20;
          end
          msg_q.push_back(c);
        end
        repeat ($urandom_range(0, 2)) msg_q.push_back("a" + 8'($urandom_range(0, 25)));
      end
      2: begin
        repeat ($urandom_range(1, 6)) msg_q.push_back("a" + 8'($urandom_range(0, 25)));
      end
      default: begin
        cut = (name_span() == 0) ? 0 : $urandom_range(0, name_span() - 1);
        for (int i = 0; i < cut; i++) msg_q.push_back(name_char(5'(i)));
        msg_q.push_back(name_letter());
      end
    endcase
    msg_q.push_back(":");
    push_value();
    push_eol();
    while ($urandom_range(0, 2) == 0) begin
      msg_q.push_back(($urandom_range(0, 1) == 1) ? mhfl_pkg::ChSp : mhfl_pkg::ChTab);
      push_value();
      push_eol();
    end
  endtask

  task automatic cut_message(input int unsigned keep);
    while (msg_q.size() > keep) void'(msg_q.pop_back());
  endtask

  // Mostly well-formed header blocks with random content; the rest is raw
  // noise or a block cut off at a random byte.
  task automatic build_message();
    msg_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) msg_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 5)) append_header(1'b1);
      case ($urandom_range(0, 2))
        1: msg_q.push_back(mhfl_pkg::ChLf);
        2: begin
          msg_q.push_back(mhfl_pkg::ChCr);
          msg_q.push_back(mhfl_pkg::ChLf);
        end
        default: ;
      endcase
      repeat ($urandom_range(0, 12)) begin
        msg_q.push_back(($urandom_range(0, 4) == 0) ? mhfl_pkg::ChLf
                                                    : 8'($urandom_range(8'h20, 8'h7E)));
      end
      if ($urandom_range(0, 4) == 0 && msg_q.size() > 1) begin
        cut_message($urandom_range(1, msg_q.size() - 1));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: reset state, empty name, case folding, continuation with
  // TAB, empty line as LF and as CR LF, headers after the block end, long name
  // length, name cut off by the message end, zero bytes, extreme bytes.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                 cfg_row;
    mhfl_pkg::cfg_idx_e sel;
    logic [63:0]        value;
    logic [7:0]         data;
    bit                 last;
    bit                 typed;
    mhfl_pkg::result_t  want;
  } dir_row_t;

  dir_row_t directed_rows[$];

  initial begin
    clear_msg_state();
    name_lo_q        = '0;
    name_hi_q        = '0;
    name_len_q       = '0;
    mismatch_count   = 0;
    random_bytes     = 0;
    idle_cycles      = 0;
    byte_gap_max     = 18;
    result_stall_max = 18;

    directed_rows = '{
      // cfg   register               value                   byte   last  typed expected
      // Empty name after reset matches the header at offset 0.
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  "A",   1'b1, 1'b1, report(1, 0, 1, 1, 0)},
      '{1'b1, mhfl_pkg::CfgNameLow,  64'h4F74, 8'h00, 1'b0, 1'b0, '0},
      '{1'b1, mhfl_pkg::CfgNameLen,  64'd2,  8'h00, 1'b0, 1'b0, '0},
      // Lone LF: header at 0 fails to match and its extent covers the LF.
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  mhfl_pkg::ChLf, 1'b1, 1'b1, report(0, 0, 0, 1, 0)},
      // "T", LF, "TO", LF, TAB "x" CR LF, LF, "Z": match with continuation.
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  "T",   1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  mhfl_pkg::ChLf,  1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  "T",   1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  "O",   1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  mhfl_pkg::ChLf,  1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  mhfl_pkg::ChTab, 1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  "x",   1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  mhfl_pkg::ChCr,  1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  mhfl_pkg::ChLf,  1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  mhfl_pkg::ChLf,  1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  "Z",   1'b1, 1'b0, '0},
      // Zero name bytes, all-ones high half, length 31 clamps to 16.
      '{1'b1, mhfl_pkg::CfgNameLow,  64'd0,  8'h00, 1'b0, 1'b0, '0},
      '{1'b1, mhfl_pkg::CfgNameHigh, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
      '{1'b1, mhfl_pkg::CfgNameLen,  64'd31, 8'h00, 1'b0, 1'b0, '0},
      // Three zero bytes: name cut off by the message end.
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  8'h00, 1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  8'h00, 1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  8'h00, 1'b1, 1'b1, report(0, 0, 0, 3, 0)},
      // 0xFF, LF, CR LF ends the block, letter after it opens nothing.
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  8'hFF, 1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  mhfl_pkg::ChLf,  1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  mhfl_pkg::ChCr,  1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  mhfl_pkg::ChLf,  1'b0, 1'b0, '0},
      '{1'b0, mhfl_pkg::CfgNameLow,  64'd0,  "a",   1'b1, 1'b0, '0}
    };

    @(posedge rst_ni);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_row) begin
        wait_until_quiet();
        write_reg(directed_rows[i].sel, directed_rows[i].value);
      end else begin
        send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                  directed_rows[i].want);
      end
    end

    // Random phases: new name registers, new idle profile, a few messages.
    // Drain now and then so the sender also waits on an empty pipeline.
    while (random_bytes < RandomBytes) begin
      wait_until_quiet();
      random_config();
      case ($urandom_range(0, 3))
        0:       byte_gap_max = 0;
        1:       byte_gap_max = $urandom_range(1, 18);
        default: byte_gap_max = 18;
      endcase
      case ($urandom_range(0, 3))
        0:       result_stall_max = 0;
        1:       result_stall_max = $urandom_range(1, 18);
        default: result_stall_max = 18;
      endcase
      repeat ($urandom_range(3, 8)) begin
        build_message();
        random_bytes += msg_q.size();
        send_message();
        if ($urandom_range(0, 3) == 0) begin
          wait_until_quiet();
        end
      end
    end

    wait_until_quiet();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_locations.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
